// File: hdl/bidt_pkg.sv
// bidt_pkg: shared types, codes and sizes of the bidirectional id/handle table
// used by every module under hdl/ but bidt_ram, depends on nothing
`timescale 1ns / 1ps

package bidt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  localparam logic [IDX_W-1:0] IDX_ZERO = '0;
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // command codes on the input item
  localparam logic [2:0] CMD_BIND        = 3'd0;
  localparam logic [2:0] CMD_FIND_ID     = 3'd1;
  localparam logic [2:0] CMD_FIND_HANDLE = 3'd2;
  localparam logic [2:0] CMD_REMOVE      = 3'd3;
  localparam logic [2:0] CMD_DRAIN       = 3'd4;
  localparam logic [2:0] CMD_CLEAR       = 3'd5;

  // status codes on the result item
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_CONFLICT = 3'd2;
  localparam logic [2:0] ST_MISSING  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic        [2:0]  command;
    logic        [63:0] net_id;
    logic signed [31:0] local_handle;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [31:0] found_handle;
    logic        [63:0] found_id;
    logic               last;
  } out_item_t;

  // operation class decided by the front end
  typedef enum logic [2:0] {
    OP_BIND,
    OP_FIND_ID,
    OP_FIND_HANDLE,
    OP_REMOVE,
    OP_DRAIN,
    OP_CLEAR,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t                op;
    logic        [63:0] net_id;
    logic signed [31:0] local_handle;
  } cq_item_t;

  typedef struct packed {
    logic        [63:0] net_id;
    logic signed [31:0] local_handle;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_SCAN,
    ENG_CHECK,
    ENG_FINISH,
    ENG_EMIT
  } eng_state_t;

endpackage

// File: hdl/bidt_ram.sv
// bidt_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bidt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// File: hdl/bidt_front.sv
// bidt_front: accepts input items, classifies the command, holds a two-entry command queue
// depends on bidt_pkg
`timescale 1ns / 1ps

module bidt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  bidt_pkg::in_item_t  in_item,
  output logic                in_full,
  input  logic                cq_pop,
  output logic                cq_valid,
  output bidt_pkg::cq_item_t  cq_item
);

  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CNT_W = $clog2(CQ_DEPTH + 1);
  localparam logic [CQ_PTR_W-1:0] PTR_ONE = CQ_PTR_W'(1);
  localparam logic [CQ_CNT_W-1:0] CNT_ONE = CQ_CNT_W'(1);
  localparam logic [CQ_CNT_W-1:0] CNT_MAX = CQ_CNT_W'(CQ_DEPTH);

  function automatic bidt_pkg::op_t classify(bidt_pkg::in_item_t it);
    logic id_ok;
    bidt_pkg::op_t op;
    id_ok = (it.net_id[63:32] != 32'd0) && (it.net_id[31:0] != 32'd0);
    case (it.command)
      bidt_pkg::CMD_BIND: begin
        op = (id_ok && (it.local_handle != 32'sd0)) ? bidt_pkg::OP_BIND
                                                    : bidt_pkg::OP_REJECT;
      end
      bidt_pkg::CMD_FIND_ID:     op = bidt_pkg::OP_FIND_ID;
      bidt_pkg::CMD_FIND_HANDLE: op = bidt_pkg::OP_FIND_HANDLE;
      bidt_pkg::CMD_REMOVE:      op = bidt_pkg::OP_REMOVE;
      bidt_pkg::CMD_DRAIN:       op = bidt_pkg::OP_DRAIN;
      bidt_pkg::CMD_CLEAR:       op = bidt_pkg::OP_CLEAR;
      default:                   op = bidt_pkg::OP_REJECT;
    endcase
    return op;
  endfunction

  bidt_pkg::cq_item_t    q_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0]   count_r, count_nxt;
  logic                  accept;
  logic                  take;
  bidt_pkg::cq_item_t    new_item;

  assign in_full  = (count_r == CNT_MAX);
  assign cq_valid = (count_r != '0);
  assign cq_item  = q_r[rd_ptr_r];
  assign accept   = in_push && !in_full;
  assign take     = cq_pop && cq_valid;

  always_comb begin
    new_item.op           = classify(in_item);
    new_item.net_id       = in_item.net_id;
    new_item.local_handle = in_item.local_handle;
  end

  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + PTR_ONE : wr_ptr_r;
    rd_ptr_nxt = take ? rd_ptr_r + PTR_ONE : rd_ptr_r;
    count_nxt  = count_r;
    if (accept && !take) begin
      count_nxt = count_r + CNT_ONE;
    end else if (take && !accept) begin
      count_nxt = count_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// File: hdl/bidt_res_queue.sv
// bidt_res_queue: two-entry result queue between the engine and the result ports
// depends on bidt_pkg
`timescale 1ns / 1ps

module bidt_res_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  bidt_pkg::out_item_t res_item,
  output logic                res_full,
  output logic                out_empty,
  input  logic                out_pop,
  output bidt_pkg::out_item_t out_item
);

  localparam int unsigned RQ_DEPTH = 2;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);
  localparam logic [RQ_PTR_W-1:0] PTR_ONE = RQ_PTR_W'(1);
  localparam logic [RQ_CNT_W-1:0] CNT_ONE = RQ_CNT_W'(1);
  localparam logic [RQ_CNT_W-1:0] CNT_MAX = RQ_CNT_W'(RQ_DEPTH);

  bidt_pkg::out_item_t q_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CNT_W-1:0] count_r, count_nxt;
  logic                put;
  logic                take;

  assign res_full  = (count_r == CNT_MAX);
  assign out_empty = (count_r == '0);
  assign out_item  = q_r[rd_ptr_r];
  assign put       = res_push && !res_full;
  assign take      = out_pop && !out_empty;

  always_comb begin
    wr_ptr_nxt = put ? wr_ptr_r + PTR_ONE : wr_ptr_r;
    rd_ptr_nxt = take ? rd_ptr_r + PTR_ONE : rd_ptr_r;
    count_nxt  = count_r;
    if (put && !take) begin
      count_nxt = count_r + CNT_ONE;
    end else if (take && !put) begin
      count_nxt = count_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      q_r[wr_ptr_r] <= res_item;
    end
  end

endmodule

// File: hdl/bidt_engine.sv
// bidt_engine: sequencer that scans the slot ram and carries out one command at a time
// depends on bidt_pkg and bidt_ram
`timescale 1ns / 1ps

module bidt_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cq_valid,
  input  bidt_pkg::cq_item_t  cq_item,
  output logic                cq_pop,
  output logic                res_push,
  input  logic                res_full,
  output bidt_pkg::out_item_t res_item
);

  bidt_pkg::eng_state_t             state_r, state_nxt;
  bidt_pkg::op_t                    op_r, op_nxt;
  logic [63:0]                      id_r, id_nxt;
  logic signed [31:0]               handle_r, handle_nxt;
  logic [bidt_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [bidt_pkg::TABLE_DEPTH-1:0] used_r, used_nxt;
  logic                             conflict_r, conflict_nxt;
  logic                             exists_r, exists_nxt;
  logic                             free_found_r, free_found_nxt;
  logic [bidt_pkg::IDX_W-1:0]       free_idx_r, free_idx_nxt;
  logic                             pend_r, pend_nxt;
  bidt_pkg::out_item_t              res_r, res_nxt;

  logic                             ram_wr_en;
  logic                             ram_rd_en;
  bidt_pkg::slot_t                  ram_wr_data;
  bidt_pkg::slot_t                  ram_rd_data;

  logic id_match;
  logic h_match;
  logic at_end;
  logic drain_stall;

  bidt_ram #(
    .WIDTH (bidt_pkg::SLOT_W),
    .DEPTH (bidt_pkg::TABLE_DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (free_idx_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  assign id_match    = (ram_rd_data.net_id == id_r);
  assign h_match     = (ram_rd_data.local_handle == handle_r);
  assign at_end      = (idx_r == bidt_pkg::LAST_IDX);
  assign drain_stall = pend_r && res_full;
  assign res_item    = res_r;

  always_comb begin
    ram_wr_data.net_id       = id_r;
    ram_wr_data.local_handle = handle_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bidt_pkg::ENG_IDLE: begin
        if (cq_valid) begin
          if (cq_item.op == bidt_pkg::OP_REJECT || cq_item.op == bidt_pkg::OP_CLEAR) begin
            state_nxt = bidt_pkg::ENG_EMIT;
          end else begin
            state_nxt = bidt_pkg::ENG_SCAN;
          end
        end
      end
      bidt_pkg::ENG_SCAN: begin
        if (used_r[idx_r]) begin
          state_nxt = bidt_pkg::ENG_CHECK;
        end else if (at_end) begin
          state_nxt = bidt_pkg::ENG_FINISH;
        end
      end
      bidt_pkg::ENG_CHECK: begin
        if ((op_r == bidt_pkg::OP_FIND_ID && id_match) ||
            (op_r == bidt_pkg::OP_REMOVE && id_match) ||
            (op_r == bidt_pkg::OP_FIND_HANDLE && h_match)) begin
          state_nxt = bidt_pkg::ENG_EMIT;
        end else if (op_r == bidt_pkg::OP_DRAIN && drain_stall) begin
          state_nxt = bidt_pkg::ENG_CHECK;
        end else if (at_end) begin
          state_nxt = bidt_pkg::ENG_FINISH;
        end else begin
          state_nxt = bidt_pkg::ENG_SCAN;
        end
      end
      bidt_pkg::ENG_FINISH: begin
        state_nxt = bidt_pkg::ENG_EMIT;
      end
      bidt_pkg::ENG_EMIT: begin
        if (!res_full) begin
          state_nxt = bidt_pkg::ENG_IDLE;
        end
      end
      default: begin
        state_nxt = bidt_pkg::ENG_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    op_nxt         = op_r;
    id_nxt         = id_r;
    handle_nxt     = handle_r;
    idx_nxt        = idx_r;
    used_nxt       = used_r;
    conflict_nxt   = conflict_r;
    exists_nxt     = exists_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    pend_nxt       = pend_r;
    res_nxt        = res_r;
    cq_pop         = 1'b0;
    res_push       = 1'b0;
    ram_rd_en      = 1'b0;
    ram_wr_en      = 1'b0;
    case (state_r)
      bidt_pkg::ENG_IDLE: begin
        if (cq_valid) begin
          cq_pop         = 1'b1;
          op_nxt         = cq_item.op;
          id_nxt         = cq_item.net_id;
          handle_nxt     = cq_item.local_handle;
          idx_nxt        = bidt_pkg::IDX_ZERO;
          conflict_nxt   = 1'b0;
          exists_nxt     = 1'b0;
          free_found_nxt = 1'b0;
          pend_nxt       = 1'b0;
          res_nxt        = '0;
          res_nxt.last   = 1'b1;
          res_nxt.status = bidt_pkg::ST_MISSING;
          if (cq_item.op == bidt_pkg::OP_REJECT) begin
            res_nxt.status = bidt_pkg::ST_INVALID;
          end else if (cq_item.op == bidt_pkg::OP_CLEAR) begin
            res_nxt.status = bidt_pkg::ST_OK;
            used_nxt       = '0;
          end
        end
      end
      bidt_pkg::ENG_SCAN: begin
        if (used_r[idx_r]) begin
          ram_rd_en = 1'b1;
        end else begin
          if (op_r == bidt_pkg::OP_BIND && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = idx_r;
          end
          if (!at_end) begin
            idx_nxt = idx_r + bidt_pkg::IDX_ONE;
          end
        end
      end
      bidt_pkg::ENG_CHECK: begin
        case (op_r)
          bidt_pkg::OP_BIND: begin
            if (h_match != id_match) begin
              conflict_nxt = 1'b1;
            end
            if (h_match && id_match) begin
              exists_nxt = 1'b1;
            end
            if (!at_end) begin
              idx_nxt = idx_r + bidt_pkg::IDX_ONE;
            end
          end
          bidt_pkg::OP_FIND_ID: begin
            if (id_match) begin
              res_nxt.status       = bidt_pkg::ST_OK;
              res_nxt.found_handle = ram_rd_data.local_handle;
            end else if (!at_end) begin
              idx_nxt = idx_r + bidt_pkg::IDX_ONE;
            end
          end
          bidt_pkg::OP_FIND_HANDLE: begin
            if (h_match) begin
              res_nxt.status   = bidt_pkg::ST_OK;
              res_nxt.found_id = ram_rd_data.net_id;
            end else if (!at_end) begin
              idx_nxt = idx_r + bidt_pkg::IDX_ONE;
            end
          end
          bidt_pkg::OP_REMOVE: begin
            if (id_match) begin
              used_nxt[idx_r] = 1'b0;
              res_nxt.status  = bidt_pkg::ST_OK;
            end else if (!at_end) begin
              idx_nxt = idx_r + bidt_pkg::IDX_ONE;
            end
          end
          bidt_pkg::OP_DRAIN: begin
            // hold one handle back so the final one can carry last
            if (!drain_stall) begin
              res_push             = pend_r;
              pend_nxt             = 1'b1;
              res_nxt.status       = bidt_pkg::ST_OK;
              res_nxt.found_handle = ram_rd_data.local_handle;
              res_nxt.found_id     = '0;
              res_nxt.last         = 1'b0;
              if (!at_end) begin
                idx_nxt = idx_r + bidt_pkg::IDX_ONE;
              end
            end
          end
          default: begin
          end
        endcase
      end
      bidt_pkg::ENG_FINISH: begin
        case (op_r)
          bidt_pkg::OP_BIND: begin
            if (conflict_r) begin
              res_nxt.status = bidt_pkg::ST_CONFLICT;
            end else if (exists_r) begin
              res_nxt.status = bidt_pkg::ST_OK;
            end else if (free_found_r) begin
              res_nxt.status       = bidt_pkg::ST_OK;
              ram_wr_en            = 1'b1;
              used_nxt[free_idx_r] = 1'b1;
            end else begin
              res_nxt.status = bidt_pkg::ST_FULL;
            end
          end
          bidt_pkg::OP_DRAIN: begin
            used_nxt = '0;
            if (pend_r) begin
              res_nxt.last = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      bidt_pkg::ENG_EMIT: begin
        res_push = !res_full;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bidt_pkg::ENG_IDLE;
      used_r       <= '0;
      pend_r       <= 1'b0;
      conflict_r   <= 1'b0;
      exists_r     <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      pend_r       <= pend_nxt;
      conflict_r   <= conflict_nxt;
      exists_r     <= exists_nxt;
      free_found_r <= free_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    handle_r   <= handle_nxt;
    idx_r      <= idx_nxt;
    free_idx_r <= free_idx_nxt;
    res_r      <= res_nxt;
  end

endmodule

// File: hdl/bidirectional_id_handle_table_top.sv
// bidirectional_id_handle_table_top: top level of the id/handle binding table
// depends on bidt_pkg, bidt_front, bidt_engine (with bidt_ram) and bidt_res_queue
`timescale 1ns / 1ps

// usage
//   input side is a queue: drive in_item and in_push, an item goes in at a
//   rising edge with in_push high and in_full low. a two-entry command queue
//   lets up to two commands wait while the engine works
//   result side is a queue too: the oldest result sits on out_item while
//   out_empty is low and leaves at an edge with out_pop high
//   every command gives one result with last set, drain gives one result per
//   bound handle in slot order, last on the final one, or a missing result if none
// scan
//   the engine walks the slot ram one slot at a time through its single read
//   port: a free slot passes the scan state, a bound one scan and check,
//   framed by dequeue, finish and hand-off. bind and drain always walk all
//   64 slots, lookups and remove stop at the hit and skip the finish step,
//   clear and rejected commands go from dequeue straight to hand-off
// stall and reset
//   when the result queue is full the engine holds in place, drain resumes
//   exactly where it stopped; in_full rises once the command queue fills
//   reset clears the bound flags of all slots, the slot ram itself is not cleared

module bidirectional_id_handle_table_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  bidt_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output bidt_pkg::out_item_t out_item
);

  // front to engine: classified command
  logic                cq_valid;
  logic                cq_pop;
  bidt_pkg::cq_item_t  cq_item;

  // engine to result queue
  logic                res_push;
  logic                res_full;
  bidt_pkg::out_item_t res_item;

  bidt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .cq_pop   (cq_pop),
    .cq_valid (cq_valid),
    .cq_item  (cq_item)
  );

  bidt_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_valid (cq_valid),
    .cq_item  (cq_item),
    .cq_pop   (cq_pop),
    .res_push (res_push),
    .res_full (res_full),
    .res_item (res_item)
  );

  bidt_res_queue u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // engine never pushes into a full result queue, no result is dropped
  assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
    else $error("engine pushed a result into a full result queue");

  // engine only takes a command that is actually waiting
  assert property (@(posedge clk) disable iff (!rst_n) cq_pop |-> cq_valid)
    else $error("engine popped an empty command queue");

  // results appear only after the engine pushed one
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_empty && !res_push) |=> out_empty)
    else $error("result appeared without an engine push");

endmodule
